/* rtl/smx_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// smx_pkg
// Shared types, codes and per-opcode stack demand for the stack machine core.
// -----------------------------------------------------------------------------
package smx_pkg;

  typedef enum logic [4:0] {
    OP_CALL    = 5'd0,
    OP_RET     = 5'd1,
    OP_JUMP    = 5'd2,
    OP_ADD     = 5'd3,
    OP_SUB     = 5'd4,
    OP_MUL     = 5'd5,
    OP_DIV     = 5'd6,
    OP_PRINT   = 5'd7,
    OP_NEWLINE = 5'd8,
    OP_PUTSTR  = 5'd9,
    OP_END     = 5'd10,
    OP_DROP    = 5'd11,
    OP_DUP     = 5'd12,
    OP_PUSH    = 5'd13,
    OP_JNZ     = 5'd14,
    OP_JZ      = 5'd15,
    OP_DEC     = 5'd16,
    OP_INC     = 5'd17,
    OP_EQUAL   = 5'd18,
    OP_GREATER = 5'd19,
    OP_LESS    = 5'd20
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRINT   = 3'd1,
    EV_NEWLINE = 3'd2,
    EV_PUTSTR  = 3'd3,
    EV_HALT    = 3'd4
  } ev_e;

  typedef enum logic [2:0] {
    FLT_OK         = 3'd0,
    FLT_DATA_UNDER = 3'd1,
    FLT_DATA_OVER  = 3'd2,
    FLT_RET_UNDER  = 3'd3,
    FLT_RET_OVER   = 3'd4,
    FLT_DIV_ZERO   = 3'd5
  } flt_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD1,
    ST_RD2,
    ST_EXEC,
    ST_DIV,
    ST_WB1,
    ST_WB2,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [4:0]         operation;
    logic signed [31:0] immediate;
  } in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic [2:0]         event_res;
    logic signed [31:0] event_value;
    logic [2:0]         fault;
  } out_t;

  localparam int unsigned PLEN_W = 17;

  // words popped from the data stack
  function automatic logic [1:0] op_pops(logic [4:0] op);
    logic [1:0] n;
    case (op_e'(op))
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQUAL, OP_GREATER, OP_LESS: n = 2'd2;
      OP_PRINT, OP_DROP, OP_JNZ, OP_JZ, OP_DUP, OP_DEC, OP_INC:      n = 2'd1;
      default:                                                       n = 2'd0;
    endcase
    return n;
  endfunction

  // words pushed onto the data stack
  function automatic logic [1:0] op_pushes(logic [4:0] op);
    logic [1:0] n;
    case (op_e'(op))
      OP_DUP: n = 2'd2;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQUAL, OP_GREATER, OP_LESS,
      OP_PUSH, OP_DEC, OP_INC: n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/smx_ram.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/smx_div.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// smx_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// -----------------------------------------------------------------------------
module smx_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output      logic        done_o,
  output      logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_sh;

  // restoring step on magnitudes, sign applied at the end
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q[31:0], quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[31] ^ divisor_i[31];
      rem_d  = '0;
      quo_d  = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule
`default_nettype wire

/* rtl/stack_machine_execute_top.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one decoded instruction of a two-stack machine per input transfer.
// -----------------------------------------------------------------------------
// Usage:
//   in_*  : one decoded instruction (opcode and 32-bit immediate) per transfer.
//   out_* : one result per instruction: next fetch address, output event,
//           event value and fault code.
//   cfg_* : writes program_length; always ready, write only while idle.
// Both stacks live in synchronous RAMs read one entry per cycle, so an
// instruction walks check, two stack reads, execute and write-back.
// Dup adds a second write-back step, divide waits on the bit-serial divider;
// halted items and stack faults go from check straight to the final step,
// end and divide by zero from execute. One instruction is in flight at a time.
// The output register lets the next input transfer be taken while a result
// still waits; a stalled receiver holds the block in its final step.
// Reset clears depths, program counter, halt flag and program_length; stack
// contents are not cleared and are only read below the current depth.
// -----------------------------------------------------------------------------
module stack_machine_execute_top #(
  parameter int DATA_DEPTH   = 256,
  parameter int RETURN_DEPTH = 64,
  parameter int PC_BITS      = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire smx_pkg::in_t                 in_data_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      smx_pkg::out_t                out_data_o,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [smx_pkg::PLEN_W-1:0]   cfg_data_i
);

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DDW = $clog2(DATA_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int RDW = $clog2(RETURN_DEPTH + 1);

  smx_pkg::state_e state_q, state_d;

  logic [4:0]                  op_q, op_d;
  logic [31:0]                 imm_q, imm_d;
  logic [31:0]                 t1_q, t1_d, t2_q, t2_d, res_q, res_d;
  logic [PC_BITS-1:0]          rtop_q, rtop_d;
  logic [DDW-1:0]              ddepth_q, ddepth_d;
  logic [RDW-1:0]              rdepth_q, rdepth_d;
  logic [PC_BITS-1:0]          pc_q, pc_d, rnpc_q, rnpc_d;
  logic                        halted_q, halted_d;
  logic [smx_pkg::PLEN_W-1:0]  plen_q;
  logic [2:0]                  rev_q, rev_d, rflt_q, rflt_d;
  logic [31:0]                 rval_q, rval_d;
  logic                        out_valid_q, out_valid_d;
  smx_pkg::out_t               out_q, out_d;

  logic [1:0]                  pops, pushes;
  logic [DDW-1:0]              dm1, dm2;
  logic [RDW-1:0]              rm1;
  logic [PC_BITS-1:0]          pc1, pc5, tgt;
  logic [31:0]                 n1, n2;

  logic                        d_we;
  logic [DAW-1:0]              d_waddr, d_raddr;
  logic [31:0]                 d_rdata;
  logic                        r_we;
  logic [PC_BITS-1:0]          r_rdata;
  logic                        div_start, div_done;
  logic [31:0]                 div_q;

  // stack memories
  smx_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dstack (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (res_q),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  smx_ram #(.WIDTH(PC_BITS), .DEPTH(RETURN_DEPTH)) u_rstack (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rdepth_q[RAW-1:0]),
    .wdata_i (pc5),
    .raddr_i (rm1[RAW-1:0]),
    .rdata_o (r_rdata)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n1),
    .divisor_i  (n2),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // address and operand helpers
  assign pops   = smx_pkg::op_pops(op_q);
  assign pushes = smx_pkg::op_pushes(op_q);
  assign dm1    = ddepth_q - DDW'(1);
  assign dm2    = ddepth_q - DDW'(2);
  assign rm1    = rdepth_q - RDW'(1);
  assign pc1    = pc_q + PC_BITS'(1);
  assign pc5    = pc_q + PC_BITS'(5);
  assign tgt    = imm_q[PC_BITS-1:0];
  assign n1     = (pops == 2'd2) ? t2_q : t1_q;
  assign n2     = t1_q;

  assign d_raddr = (state_q == smx_pkg::ST_CHECK) ? dm1[DAW-1:0] : dm2[DAW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    imm_d       = imm_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    rtop_d      = rtop_q;
    res_d       = res_q;
    ddepth_d    = ddepth_q;
    rdepth_d    = rdepth_q;
    pc_d        = pc_q;
    halted_d    = halted_q;
    rnpc_d      = rnpc_q;
    rev_d       = rev_q;
    rval_d      = rval_q;
    rflt_d      = rflt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    d_we        = 1'b0;
    d_waddr     = '0;
    r_we        = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      smx_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = in_data_i.operation;
          imm_d   = in_data_i.immediate;
          state_d = smx_pkg::ST_CHECK;
        end
      end
      smx_pkg::ST_CHECK: begin
        rnpc_d  = pc_q;
        rev_d   = smx_pkg::EV_NONE;
        rval_d  = '0;
        rflt_d  = smx_pkg::FLT_OK;
        state_d = smx_pkg::ST_DONE;
        if (halted_q || (32'(pc_q) >= 32'(plen_q))) begin
          halted_d = 1'b1;
          rev_d    = smx_pkg::EV_HALT;
        end else if (op_q == smx_pkg::OP_CALL && rdepth_q == RDW'(RETURN_DEPTH)) begin
          rflt_d = smx_pkg::FLT_RET_OVER;
        end else if (op_q == smx_pkg::OP_RET && rdepth_q == '0) begin
          rflt_d = smx_pkg::FLT_RET_UNDER;
        end else if (ddepth_q < DDW'(pops)) begin
          rflt_d = smx_pkg::FLT_DATA_UNDER;
        end else if (pushes > pops && ddepth_q == DDW'(DATA_DEPTH)) begin
          rflt_d = smx_pkg::FLT_DATA_OVER;
        end else begin
          state_d = smx_pkg::ST_RD1;
        end
      end
      smx_pkg::ST_RD1: begin
        t1_d    = d_rdata;
        rtop_d  = r_rdata;
        state_d = smx_pkg::ST_RD2;
      end
      smx_pkg::ST_RD2: begin
        t2_d    = d_rdata;
        state_d = smx_pkg::ST_EXEC;
      end
      smx_pkg::ST_EXEC: begin
        rnpc_d  = pc1;
        res_d   = '0;
        state_d = smx_pkg::ST_WB1;
        case (smx_pkg::op_e'(op_q))
          smx_pkg::OP_CALL:    rnpc_d = tgt;
          smx_pkg::OP_RET:     rnpc_d = rtop_q;
          smx_pkg::OP_JUMP:    rnpc_d = tgt;
          smx_pkg::OP_ADD:     res_d  = n1 + n2;
          smx_pkg::OP_SUB:     res_d  = n1 - n2;
          smx_pkg::OP_MUL:     res_d  = n1 * n2;
          smx_pkg::OP_DIV: begin
            if (n2 == '0) begin
              rnpc_d  = pc_q;
              rflt_d  = smx_pkg::FLT_DIV_ZERO;
              state_d = smx_pkg::ST_DONE;
            end else begin
              div_start = 1'b1;
              state_d   = smx_pkg::ST_DIV;
            end
          end
          smx_pkg::OP_PRINT: begin
            rev_d  = smx_pkg::EV_PRINT;
            rval_d = n1;
          end
          smx_pkg::OP_NEWLINE: rev_d = smx_pkg::EV_NEWLINE;
          smx_pkg::OP_PUTSTR: begin
            rev_d  = smx_pkg::EV_PUTSTR;
            rval_d = imm_q;
            rnpc_d = pc5;
          end
          smx_pkg::OP_END: begin
            halted_d = 1'b1;
            rev_d    = smx_pkg::EV_HALT;
            rnpc_d   = pc_q;
            state_d  = smx_pkg::ST_DONE;
          end
          smx_pkg::OP_DUP:     res_d  = n1;
          smx_pkg::OP_PUSH: begin
            res_d  = imm_q;
            rnpc_d = pc5;
          end
          smx_pkg::OP_JNZ:     rnpc_d = (n1 != '0) ? tgt : pc5;
          smx_pkg::OP_JZ:      rnpc_d = (n1 == '0) ? tgt : pc5;
          smx_pkg::OP_DEC:     res_d  = n1 - 32'd1;
          smx_pkg::OP_INC:     res_d  = n1 + 32'd1;
          smx_pkg::OP_EQUAL:   res_d  = {31'd0, n1 == n2};
          smx_pkg::OP_GREATER: res_d  = {31'd0, $signed(n1) > $signed(n2)};
          smx_pkg::OP_LESS:    res_d  = {31'd0, $signed(n1) < $signed(n2)};
          default: ;
        endcase
      end
      smx_pkg::ST_DIV: begin
        if (div_done) begin
          res_d   = div_q;
          state_d = smx_pkg::ST_WB1;
        end
      end
      smx_pkg::ST_WB1: begin
        d_we     = (pushes != 2'd0);
        d_waddr  = DAW'(ddepth_q - DDW'(pops));
        ddepth_d = ddepth_q - DDW'(pops) + DDW'(pushes);
        if (op_q == smx_pkg::OP_CALL) begin
          r_we     = 1'b1;
          rdepth_d = rdepth_q + RDW'(1);
        end else if (op_q == smx_pkg::OP_RET) begin
          rdepth_d = rm1;
        end
        pc_d    = rnpc_q;
        state_d = (pushes == 2'd2) ? smx_pkg::ST_WB2 : smx_pkg::ST_DONE;
      end
      smx_pkg::ST_WB2: begin
        // second copy for dup, depth already advanced
        d_we    = 1'b1;
        d_waddr = dm1[DAW-1:0];
        state_d = smx_pkg::ST_DONE;
      end
      smx_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.next_pc     = 16'(32'(rnpc_q));
          out_d.event_res   = rev_q;
          out_d.event_value = rval_q;
          out_d.fault       = rflt_q;
          out_valid_d       = 1'b1;
          state_d           = smx_pkg::ST_IDLE;
        end
      end
      default: state_d = smx_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smx_pkg::ST_IDLE;
      ddepth_q    <= '0;
      rdepth_q    <= '0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ddepth_q    <= ddepth_d;
      rdepth_q    <= rdepth_d;
      pc_q        <= pc_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        plen_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    imm_q  <= imm_d;
    t1_q   <= t1_d;
    t2_q   <= t2_d;
    rtop_q <= rtop_d;
    res_q  <= res_d;
    rnpc_q <= rnpc_d;
    rev_q  <= rev_d;
    rval_q <= rval_d;
    rflt_q <= rflt_d;
    out_q  <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ddepth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddepth_q <= DDW'(DATA_DEPTH)) else $error("data depth beyond capacity");
  a_rdepth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdepth_q <= RDW'(RETURN_DEPTH)) else $error("return depth beyond capacity");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt flag cleared");
  a_fault_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault != smx_pkg::FLT_OK)
      |-> out_data_o.event_res == smx_pkg::EV_NONE)
    else $error("faulted result carries an event");
`endif

endmodule
`default_nettype wire
